/* design/assert_macros.svh */
// Assertion macros for the validator design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HSV_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define HSV_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define HSV_ASSERT_IMP(label, clk, rst_n, a, c)
`define HSV_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

/* design/hsv_pkg.sv */
package hsv_pkg;
  typedef enum logic [4:0] {
    PH_HTYPE, PH_HLEN, PH_OTHER, PH_FIN, PH_CV_ALG, PH_CV_LEN, PH_CV_SIG,
    PH_EE_LIST, PH_EE_TYPE, PH_EE_LEN, PH_EE_DATA, PH_AL_LIST, PH_AL_PLEN,
    PH_AL_NAME, PH_CT_CLEN, PH_CT_CTX, PH_CT_LIST, PH_CT_CERT, PH_CT_DER,
    PH_CT_ELEN, PH_CT_EXT, PH_CT_REST
  } phase_e;

  localparam logic [7:0]  TypeEe   = 8'd8;
  localparam logic [7:0]  TypeCert = 8'd11;
  localparam logic [7:0]  TypeCv   = 8'd15;
  localparam logic [7:0]  TypeFin  = 8'd20;
  localparam logic [15:0] ExtAlpn  = 16'h0010;
  localparam logic [23:0] FinLen   = 24'd32;
  localparam logic [23:0] MaxBodyReset = 24'd16380;

  localparam logic [3:0] RgHeader = 4'd0;
  localparam logic [3:0] RgLen    = 4'd1;
  localparam logic [3:0] RgAlpn   = 4'd2;
  localparam logic [3:0] RgCtx    = 4'd3;
  localparam logic [3:0] RgDer    = 4'd4;
  localparam logic [3:0] RgCExt   = 4'd5;
  localparam logic [3:0] RgLater  = 4'd6;
  localparam logic [3:0] RgSig    = 4'd7;
  localparam logic [3:0] RgVerify = 4'd8;
  localparam logic [3:0] RgBody   = 4'd9;
  localparam logic [3:0] RgExtDat = 4'd10;

  localparam logic [2:0] StBusy   = 3'd0;
  localparam logic [2:0] StOk     = 3'd1;
  localparam logic [2:0] StBad    = 3'd2;
  localparam logic [2:0] StLong   = 3'd3;
  localparam logic [2:0] StHalted = 3'd4;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  ctype;
    logic [23:0] body_rem;
    logic [23:0] field_rem;
    logic [23:0] outer_rem;
    logic [23:0] shift;
    logic [2:0]  idx;
    logic [15:0] ext_kind;
    logic        alpn;
    logic        err;
  } pstate_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] mtype;
    logic [3:0] region;
    logic       start;
    logic       stop;
    logic [2:0] status;
    logic       alpn;
  } result_t;
endpackage

/* design/hsv_parse.sv */
module hsv_parse import hsv_pkg::*; (
  input  pstate_t     cur_i,
  input  logic [7:0]  byte_i,
  input  logic        restart_i,
  input  logic [23:0] max_len_i,
  output pstate_t     nxt_o,
  output result_t     res_o
);
  // Next state and result for one byte
  always_comb begin
    pstate_t s;
    pstate_t n;
    logic bad;
    logic done;
    logic [23:0] acc;
    logic [2:0]  idx1;
    logic [23:0] bsum;
    logic [3:0] region;
    logic start;
    logic stop;
    logic [2:0] status;
    s = cur_i;
    if (restart_i) begin
      s = '0;
      s.phase = PH_HTYPE;
    end
    n = s;
    bad = 1'b0;
    region = RgHeader;
    start = 1'b0;
    stop = 1'b0;
    status = StBusy;
    // shift accumulator, as shared by all multi-byte fields
    acc = (s.idx == 3'd0) ? {16'd0, byte_i} : {s.shift[15:0], byte_i};
    idx1 = s.idx + 3'd1;
    bsum = {16'd0, byte_i};
    done = 1'b0;
    if (s.err) begin
      res_o = '{out_byte: byte_i, mtype: s.ctype, region: RgHeader, start: 1'b0,
                stop: 1'b0, status: StHalted, alpn: 1'b0};
      nxt_o = s;
    end else begin
      if (s.phase == PH_HTYPE) begin
        n.ctype = byte_i;
        n.alpn = 1'b0;
        start = 1'b1;
        n.idx = 3'd0;
        n.phase = PH_HLEN;
      end else if (s.phase == PH_HLEN) begin
        region = RgLen;
        n.shift = acc;
        n.idx = idx1;
        if (idx1 >= 3'd3) begin
          n.idx = 3'd0;
          n.body_rem = acc;
          if (acc > max_len_i) begin
            status = StLong;
            n.err = 1'b1;
          end else if (s.ctype == TypeEe) begin
            bad = acc < 24'd2; n.phase = PH_EE_LIST;
          end else if (s.ctype == TypeCert) begin
            bad = acc < 24'd4; n.phase = PH_CT_CLEN;
          end else if (s.ctype == TypeCv) begin
            bad = acc < 24'd4; n.phase = PH_CV_ALG;
          end else if (s.ctype == TypeFin) begin
            bad = acc != FinLen; n.phase = PH_FIN;
          end else begin
            n.phase = PH_OTHER;
            if (acc == 24'd0) begin
              stop = 1'b1; status = StOk; n.phase = PH_HTYPE;
            end
          end
        end
      end else begin
        if (s.body_rem != 24'd0) n.body_rem = s.body_rem - 24'd1;
        // two- or three-byte field gathering
        case (s.phase)
          PH_CV_ALG, PH_CV_LEN, PH_EE_LIST, PH_EE_TYPE, PH_EE_LEN, PH_AL_LIST,
          PH_CT_ELEN:
            done = (idx1 >= 3'd2);
          PH_CT_LIST, PH_CT_CERT:
            done = (idx1 >= 3'd3);
          default: done = 1'b0;
        endcase
        case (s.phase)
          PH_CV_ALG, PH_CV_LEN, PH_EE_LIST, PH_EE_LEN, PH_AL_LIST,
          PH_CT_ELEN, PH_CT_LIST, PH_CT_CERT: begin
            n.shift = acc;
            n.idx = done ? 3'd0 : idx1;
          end
          default: ;
        endcase
        case (s.phase)
          PH_FIN: region = RgVerify;
          PH_CV_ALG: begin
            region = RgBody;
            if (done) n.phase = PH_CV_LEN;
          end
          PH_CV_LEN: begin
            region = RgLen;
            if (done) begin
              bad = acc == 24'd0 || acc != n.body_rem;
              n.phase = PH_CV_SIG;
            end
          end
          PH_CV_SIG: region = RgSig;
          PH_EE_LIST: begin
            region = RgLen;
            if (done) begin
              bad = acc != n.body_rem;
              n.phase = PH_EE_TYPE;
            end
          end
          PH_EE_TYPE: begin
            region = RgBody;
            if (s.idx == 3'd0 && n.body_rem < 24'd3) begin
              bad = 1'b1;
            end else begin
              n.shift = acc;
              n.idx = done ? 3'd0 : idx1;
              if (done) begin
                n.ext_kind = acc[15:0];
                n.phase = PH_EE_LEN;
              end
            end
          end
          PH_EE_LEN: begin
            region = RgLen;
            if (done) begin
              if (acc > n.body_rem) begin
                bad = 1'b1;
              end else if (s.ext_kind == ExtAlpn) begin
                bad = acc < 24'd3;
                n.outer_rem = acc;
                n.phase = PH_AL_LIST;
              end else begin
                n.field_rem = acc;
                n.phase = (acc != 24'd0) ? PH_EE_DATA : PH_EE_TYPE;
              end
            end
          end
          PH_EE_DATA, PH_AL_NAME, PH_CT_CTX, PH_CT_DER, PH_CT_EXT: begin
            case (s.phase)
              PH_EE_DATA: region = RgExtDat;
              PH_AL_NAME: region = RgAlpn;
              PH_CT_CTX:  region = RgCtx;
              PH_CT_DER:  region = RgDer;
              default:    region = RgCExt;
            endcase
            if (s.field_rem != 24'd0) n.field_rem = s.field_rem - 24'd1;
            if (n.field_rem == 24'd0) begin
              case (s.phase)
                PH_EE_DATA, PH_AL_NAME: n.phase = PH_EE_TYPE;
                PH_CT_CTX:  n.phase = PH_CT_LIST;
                PH_CT_DER:  n.phase = PH_CT_ELEN;
                default:    n.phase = PH_CT_REST;
              endcase
            end
          end
          PH_AL_LIST: begin
            region = RgLen;
            if (done) begin
              bad = (acc + 24'd2) != s.outer_rem || acc < 24'd1;
              n.field_rem = acc;
              n.phase = PH_AL_PLEN;
            end
          end
          PH_AL_PLEN: begin
            region = RgLen;
            if (byte_i == 8'd0 || (bsum + 24'd1) != s.field_rem) begin
              bad = 1'b1;
            end else begin
              n.alpn = 1'b1;
              n.field_rem = bsum;
              n.phase = PH_AL_NAME;
            end
          end
          PH_CT_CLEN: begin
            region = RgLen;
            if ((bsum + 24'd3) > n.body_rem) begin
              bad = 1'b1;
            end else begin
              n.field_rem = bsum;
              n.phase = (byte_i != 8'd0) ? PH_CT_CTX : PH_CT_LIST;
            end
          end
          PH_CT_LIST: begin
            region = RgLen;
            if (done) begin
              bad = acc != n.body_rem || acc < 24'd5;
              n.phase = PH_CT_CERT;
            end
          end
          PH_CT_CERT: begin
            region = RgLen;
            if (done) begin
              bad = acc == 24'd0 || ({1'b0, acc} + 25'd2) > {1'b0, n.body_rem};
              n.field_rem = acc;
              n.phase = PH_CT_DER;
            end
          end
          PH_CT_ELEN: begin
            region = RgLen;
            if (done) begin
              bad = acc > n.body_rem;
              n.field_rem = acc;
              n.phase = (acc != 24'd0) ? PH_CT_EXT : PH_CT_REST;
            end
          end
          PH_CT_REST: region = RgLater;
          default: region = RgBody;
        endcase
        if (!bad && n.body_rem == 24'd0) begin
          stop = 1'b1; status = StOk; n.phase = PH_HTYPE;
        end
      end
      if (bad) begin
        status = StBad; stop = 1'b0; n.err = 1'b1;
      end
      nxt_o = n;
      res_o = '{out_byte: byte_i, mtype: n.ctype, region: region, start: start,
                stop: stop, status: status, alpn: n.alpn};
    end
  end
endmodule

/* design/handshake_stream_validator_core.sv */
// The result is registered and valid in the cycle after input accept.
// Throughput: one byte per cycle while the output does not stall; the parse state register closes the only loop.
// The input stalls only while a result is held under an output stall.
// Reset: asynchronous, active low; parser returns to message start, limit to 16380.
`include "assert_macros.svh"
module handshake_stream_validator_core import hsv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic [7:0]  message_type_o,
  output logic [3:0]  region_o,
  output logic        message_start_o,
  output logic        message_end_o,
  output logic [2:0]  status_o,
  output logic        alpn_seen_o
);
  logic [23:0] max_len_q;
  pstate_t     st_q, st_d;
  result_t     res_d, res_q;
  logic        ov_q;
  logic        acc_in;

  // accept while output is empty or leaving
  assign in_stall_o = ov_q && out_stall_i;
  assign acc_in = in_valid_i && !in_stall_o;

  hsv_parse u_parse (
    .cur_i(st_q), .byte_i(data_byte_i), .restart_i(restart_i),
    .max_len_i(max_len_q), .nxt_o(st_d), .res_o(res_d)
  );

  // hold limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) max_len_q <= MaxBodyReset;
    else if (cfg_we_i) max_len_q <= cfg_wdata_i;
  end

  // advance parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
      ov_q <= 1'b0;
    end else begin
      if (acc_in) st_q <= st_d;
      if (acc_in) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  // capture result
  always_ff @(posedge clk_i) begin
    if (acc_in) res_q <= res_d;
  end

  assign out_valid_o = ov_q;
  assign out_byte_o = res_q.out_byte;
  assign message_type_o = res_q.mtype;
  assign region_o = res_q.region;
  assign message_start_o = res_q.start;
  assign message_end_o = res_q.stop;
  assign status_o = res_q.status;
  assign alpn_seen_o = res_q.alpn;

  `HSV_ASSERT_NXT(a_err_halts, clk_i, rst_ni, acc_in && !restart_i && st_q.err, out_valid_o && status_o == StHalted)
  `HSV_ASSERT_IMP(a_end_ok, clk_i, rst_ni, out_valid_o && message_end_o, status_o == StOk)
  `HSV_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(res_q))
endmodule
